// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the row generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define AST_HOLDS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define AST_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication checked in the next cycle.
`define AST_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/emrg_pkg.sv =====
// ----------------------------------------------------------------------------
// Eller maze row generator package
// Shared constants, column lane state and command types.
// ----------------------------------------------------------------------------
package emrg_pkg;

  localparam int COLUMNS  = 32;
  localparam int LABEL_W  = $clog2(COLUMNS);
  localparam int STEP_W   = $clog2(COLUMNS);
  localparam int RIGHT_W  = 31;
  localparam int BOTTOM_W = 32;

  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [COLUMNS-1:0] col_vec_t;

  // Everything one column carries while a row is being built.
  typedef struct packed {
    label_t label;
    logic   wall;
    logic   rwall;
    logic   rwish;
    logic   bwish;
  } lane_state_t;

  // Broadcast from the sequencer to every lane; head writes touch lane 0 only.
  typedef struct packed {
    logic   load;
    logic   rotate;
    logic   merge_en;
    label_t merge_from;
    label_t merge_to;
    logic   head_label_we;
    label_t head_label;
    logic   head_wall_we;
    logic   head_wall;
    logic   head_rw_we;
    logic   head_rw;
    logic   clear_walls;
    logic   set_walls;
    label_t probe;
  } lane_cmd_t;

  // What the merging stage reports back to the sequencer.
  typedef struct packed {
    col_vec_t used;
    logic     open_many;
    logic     free_found;
    label_t   free_label;
  } merge_status_t;

endpackage

// ===== src/eller_maze_row_generator.sv =====
// ----------------------------------------------------------------------------
// Eller maze row generator
// Builds one maze row per input beat with Eller's algorithm, using one lane
// per column and a shared merging stage.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | right_wall_wish, bottom_wall_wish, last_row
//  output   | out_valid / out_ready| right_walls, bottom_walls, maze_done
//
// To build a row, the lane contents rotate past lane 0 once for fresh labels,
// once for right walls, once for bottom walls and, on the last row, once for
// the join.
// Reset closes all previous bottom walls; labels need no reset.
// in_ready is high only while no row is in progress; a finished row waits
// in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eller_maze_row_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [emrg_pkg::RIGHT_W-1:0]     right_wall_wish,
  input  logic [emrg_pkg::BOTTOM_W-1:0]    bottom_wall_wish,
  input  logic                             last_row,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [emrg_pkg::RIGHT_W-1:0]     right_walls,
  output logic [emrg_pkg::BOTTOM_W-1:0]    bottom_walls,
  output logic                             maze_done
);
  import emrg_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FRESH  = 3'd1;
  localparam logic [2:0] ST_RIGHT  = 3'd2;
  localparam logic [2:0] ST_BOTTOM = 3'd3;
  localparam logic [2:0] ST_JOIN   = 3'd4;
  localparam logic [2:0] ST_WRITE  = 3'd5;

  localparam step_t STEP_LAST = step_t'(COLUMNS - 1);

  logic [2:0]    state;
  logic [2:0]    state_next;
  step_t         step;
  logic          last_r;
  col_vec_t      used;
  col_vec_t      used_next;
  lane_cmd_t     cmd;
  merge_status_t mst;
  logic          in_beat;
  logic          out_load;
  logic          step_end;

  lane_state_t   cur_s    [COLUMNS];
  lane_state_t   upd_s    [COLUMNS];
  col_vec_t      used_hot [COLUMNS];
  col_vec_t      open_hits;
  col_vec_t      wall_vec;
  logic [RIGHT_W-1:0] rw_vec;

  genvar j;
  generate
    for (j = 0; j < COLUMNS; j++) begin : g_lane
      logic rwish_in;
      logic bwish_in;
      if (j < RIGHT_W) begin : g_rw
        assign rwish_in  = right_wall_wish[j];
        assign rw_vec[j] = cur_s[j].rwall;
      end else begin : g_no_rw
        assign rwish_in = 1'b0;
      end
      if (j < BOTTOM_W) begin : g_bw
        assign bwish_in = bottom_wall_wish[j];
      end else begin : g_no_bw
        assign bwish_in = 1'b0;
      end

      emrg_lane u_lane (
        .clk        (clk),
        .rst        (rst),
        .is_head    ((j == 0) ? 1'b1 : 1'b0),
        .cmd        (cmd),
        .load_rwish (rwish_in),
        .load_bwish (bwish_in),
        .nbr        (upd_s[(j + 1) % COLUMNS]),
        .cur        (cur_s[j]),
        .upd        (upd_s[j]),
        .used_hot   (used_hot[j]),
        .open_hit   (open_hits[j])
      );

      assign wall_vec[j] = cur_s[j].wall;
    end
  endgenerate

  emrg_merge u_merge (
    .used_hot  (used_hot),
    .open_hits (open_hits),
    .taken     (used),
    .status    (mst)
  );

  assign in_ready = (state == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_load = (state == ST_WRITE) && (!out_valid || out_ready);
  assign step_end = (step == STEP_LAST);

  always_comb begin
    cmd        = '0;
    cmd.probe  = cur_s[0].label;
    state_next = state;
    used_next  = used;
    unique case (state)
      ST_IDLE: begin
        cmd.load = in_beat;
        if (in_beat) begin
          used_next  = mst.used;
          state_next = ST_FRESH;
        end
      end
      ST_FRESH: begin
        cmd.rotate = 1'b1;
        // A cell under a wall takes the lowest label nobody holds yet.
        if (cur_s[0].wall) begin
          cmd.head_label_we = 1'b1;
          cmd.head_label    = mst.free_found ? mst.free_label : '0;
          used_next         = used | (col_vec_t'(1) << cmd.head_label);
        end
        cmd.clear_walls = step_end;
        if (step_end) begin
          state_next = ST_RIGHT;
        end
      end
      ST_RIGHT: begin
        cmd.rotate = 1'b1;
        if (!step_end) begin
          if (cur_s[0].rwish || (cur_s[0].label == cur_s[1].label)) begin
            cmd.head_rw_we = 1'b1;
            cmd.head_rw    = 1'b1;
          end else begin
            cmd.merge_en   = 1'b1;
            cmd.merge_from = cur_s[1].label;
            cmd.merge_to   = cur_s[0].label;
          end
        end else begin
          state_next = ST_BOTTOM;
        end
      end
      ST_BOTTOM: begin
        cmd.rotate       = 1'b1;
        cmd.head_wall_we = 1'b1;
        cmd.head_wall    = cur_s[0].bwish && mst.open_many;
        if (step_end) begin
          state_next = last_r ? ST_JOIN : ST_WRITE;
        end
      end
      ST_JOIN: begin
        cmd.rotate = 1'b1;
        if (!step_end) begin
          if (cur_s[0].label != cur_s[1].label) begin
            cmd.head_rw_we = 1'b1;
            cmd.head_rw    = 1'b0;
          end
          cmd.merge_en   = 1'b1;
          cmd.merge_from = cur_s[1].label;
          cmd.merge_to   = cur_s[0].label;
        end else begin
          // Closing every bottom wall also restores the reset state.
          cmd.set_walls = 1'b1;
          state_next    = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (cmd.rotate) begin
        step <= step_end ? '0 : step + step_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    used <= used_next;
    if (in_beat) begin
      last_r <= last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      right_walls  <= rw_vec;
      bottom_walls <= wall_vec[BOTTOM_W-1:0];
      maze_done    <= last_r;
    end
  end

  `AST_NEXT(a_accept_starts, clk, rst, in_beat, state == ST_FRESH, "beat did not start a row")
  `AST_SAME(a_idle_aligned, clk, rst, state == ST_IDLE, step == '0, "lanes not aligned")
  `AST_SAME(a_join_last, clk, rst, state == ST_JOIN, last_r, "join on a row not last")
  `AST_SAME(a_last_closed, clk, rst, state == ST_WRITE && last_r, &wall_vec, "floor open")
  `AST_SAME(a_label_pool, clk, rst, state == ST_FRESH && cur_s[0].wall, mst.free_found, "no label")

endmodule

// ===== src/emrg_lane.sv =====
// ----------------------------------------------------------------------------
// Eller maze column lane
// Holds one column's label and wall bits, applies set merges and head writes,
// and rotates its contents one place toward lane 0 on every sweep step.
// ----------------------------------------------------------------------------
module emrg_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   is_head,
  input  emrg_pkg::lane_cmd_t    cmd,
  input  logic                   load_rwish,
  input  logic                   load_bwish,
  input  emrg_pkg::lane_state_t  nbr,
  output emrg_pkg::lane_state_t  cur,
  output emrg_pkg::lane_state_t  upd,
  output emrg_pkg::col_vec_t     used_hot,
  output logic                   open_hit
);
  import emrg_pkg::*;

  label_t label;
  logic   wall;
  logic   rwall;
  logic   rwish;
  logic   bwish;

  assign cur = '{label, wall, rwall, rwish, bwish};

  always_comb begin
    upd = cur;
    if (is_head && cmd.head_label_we) begin
      upd.label = cmd.head_label;
    end else if (cmd.merge_en && (label == cmd.merge_from)) begin
      upd.label = cmd.merge_to;
    end
    if (cmd.clear_walls) begin
      upd.wall = 1'b0;
    end else if (cmd.set_walls) begin
      upd.wall = 1'b1;
    end else if (is_head && cmd.head_wall_we) begin
      upd.wall = cmd.head_wall;
    end
    if (is_head && cmd.head_rw_we) begin
      upd.rwall = cmd.head_rw;
    end
  end

  // A column open at the bottom carries its label into the next row.
  assign used_hot = wall ? '0 : (col_vec_t'(1) << label);
  assign open_hit = !wall && (label == cmd.probe);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rwish <= load_rwish;
      bwish <= load_bwish;
      rwall <= 1'b0;
    end else if (cmd.rotate) begin
      label <= nbr.label;
      rwall <= nbr.rwall;
      rwish <= nbr.rwish;
      bwish <= nbr.bwish;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wall <= 1'b1;
    end else if (cmd.rotate) begin
      wall <= nbr.wall;
    end
  end

endmodule

// ===== src/emrg_merge.sv =====
// ----------------------------------------------------------------------------
// Eller maze lane merge
// Combines the lane outputs: labels carried down, whether the probed set has
// more than one open cell, and the lowest label still free.
// ----------------------------------------------------------------------------
module emrg_merge (
  input  emrg_pkg::col_vec_t        used_hot [emrg_pkg::COLUMNS],
  input  emrg_pkg::col_vec_t        open_hits,
  input  emrg_pkg::col_vec_t        taken,
  output emrg_pkg::merge_status_t   status
);
  import emrg_pkg::*;

  col_vec_t used_or;
  col_vec_t free_vec;
  col_vec_t free_low;
  label_t   free_idx;

  always_comb begin
    used_or = '0;
    for (int j = 0; j < COLUMNS; j++) begin
      used_or = used_or | used_hot[j];
    end
  end

  // Isolate the lowest free label, then encode the one-hot position.
  assign free_vec = ~taken;
  assign free_low = free_vec & (~free_vec + col_vec_t'(1));

  always_comb begin
    free_idx = '0;
    for (int j = 0; j < COLUMNS; j++) begin
      if (free_low[j]) begin
        free_idx = free_idx | label_t'(j);
      end
    end
  end

  assign status.used       = used_or;
  assign status.open_many  = (open_hits & (open_hits - col_vec_t'(1))) != '0;
  assign status.free_found = |free_vec;
  assign status.free_label = free_idx;

endmodule
